// ===== rtl/rgb_box_blur_clipped_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef RGB_BOX_BLUR_CLIPPED_MACROS_SVH
`define RGB_BOX_BLUR_CLIPPED_MACROS_SVH

`define BB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define BB_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define BB_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bblur_pkg.sv =====
package bblur_pkg;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_CHECK,
      BK_READ,
      BK_FLUSH,
      BK_PREP,
      BK_DIV,
      BK_OUT
   } back_state_type;

   typedef struct packed {
      logic drain;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   localparam int CH_W = 8;

endpackage

// ===== rtl/bblur_ram.sv =====
module bblur_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 26624
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/bblur_queue.sv =====
`include "rgb_box_blur_clipped_macros.svh"

module bblur_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  bblur_pkg::cmd_type       push_data,
   input  logic                     pop,
   output bblur_pkg::cmd_type       pop_data,
   output bblur_pkg::q_status_type  status
);

   bblur_pkg::cmd_type entry_ff [2];
   logic               wr_ptr_ff, rd_ptr_ff;
   logic [1:0]         count_ff;
   logic               wr_ptr_in, rd_ptr_in;
   logic [1:0]         count_in;

   assign status.empty = (count_ff == 2'd0);
   assign status.full  = (count_ff == 2'd2);
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `BB_IMPLY(a_no_overflow, clock, reset, push, !status.full || pop, "queue overflow")
   `BB_IMPLY(a_no_underflow, clock, reset, pop, !status.empty, "queue underflow")
   `BB_ASSERT(a_count_range, clock, reset, count_ff != 2'd3, "queue count corrupt")

endmodule

// ===== rtl/bblur_front.sv =====
`include "rgb_box_blur_clipped_macros.svh"

module bblur_front #(
   parameter int RADIUS     = 6,
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     restart,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]           width_eff,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]          height_eff,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic                                     req_operation,
   input  logic [7:0]                               req_red,
   input  logic [7:0]                               req_green,
   input  logic [7:0]                               req_blue,
   input  logic                                     back_idle,
   input  bblur_pkg::q_status_type                  q_stat,
   output logic                                     push,
   output bblur_pkg::cmd_type                       push_data,
   output logic                                     wr_en,
   output logic [$clog2((2*RADIUS+1)*MAX_WIDTH)-1:0] wr_addr,
   output logic [3*bblur_pkg::CH_W-1:0]             wr_data,
   output logic [$clog2(MAX_HEIGHT+1)-1:0]          in_row,
   output logic [$clog2(MAX_WIDTH+1)-1:0]           in_col
);

   localparam int LINES  = 2 * RADIUS + 1;
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
   localparam int COL_W  = $clog2(MAX_WIDTH + 1);
   localparam int RING_W = $clog2(LINES);
   localparam int ADDR_W = $clog2(LINES * MAX_WIDTH);

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [RING_W-1:0] ring_ff, ring_in;
   logic              accept, take_pixel;

   // Only one item is in flight: the back end must be finished with the
   // line store before the next pixel may overwrite it.
   assign req_stall  = !(q_stat.empty && back_idle);
   assign accept     = req_valid && !req_stall;
   assign take_pixel = accept && (req_operation == bblur_pkg::OP_PIXEL)
                       && (row_ff < height_eff);

   assign push            = accept && ((req_operation == bblur_pkg::OP_DRAIN) || take_pixel);
   assign push_data.drain = (req_operation == bblur_pkg::OP_DRAIN);

   assign wr_en   = take_pixel;
   assign wr_addr = ADDR_W'(ring_ff * MAX_WIDTH) + ADDR_W'(col_ff);
   assign wr_data = {req_red, req_green, req_blue};
   assign in_row  = row_ff;
   assign in_col  = col_ff;

   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      ring_in = ring_ff;
      if (restart) begin
         row_in  = '0;
         col_in  = '0;
         ring_in = '0;
      end else if (take_pixel) begin
         if (col_ff + 1'b1 >= width_eff) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
            ring_in = (ring_ff == RING_W'(LINES - 1)) ? '0 : ring_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         ring_ff <= '0;
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         ring_ff <= ring_in;
      end
   end

   `BB_IMPLY(a_write_in_frame, clock, reset, wr_en, row_ff < height_eff, "write past frame")
   `BB_IMPLY(a_ring_range, clock, reset, 1'b1, ring_ff < RING_W'(LINES), "ring index out of range")
   `BB_IMPLY(a_stall_busy, clock, reset, !back_idle, req_stall, "input open while back end busy")

endmodule

// ===== rtl/bblur_back.sv =====
`include "rgb_box_blur_clipped_macros.svh"

module bblur_back #(
   parameter int RADIUS     = 6,
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     restart,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]           width_eff,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]          height_eff,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]          in_row,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]           in_col,
   input  bblur_pkg::q_status_type                  q_stat,
   input  bblur_pkg::cmd_type                       q_data,
   output logic                                     pop,
   output logic                                     idle,
   output logic                                     frame_restart,
   output logic [$clog2((2*RADIUS+1)*MAX_WIDTH)-1:0] rd_addr,
   input  logic [3*bblur_pkg::CH_W-1:0]             rd_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [7:0]                               rsp_blurred_red,
   output logic [7:0]                               rsp_blurred_green,
   output logic [7:0]                               rsp_blurred_blue,
   output logic                                     rsp_last_of_run,
   output logic                                     rsp_frame_done
);

   localparam int LINES  = 2 * RADIUS + 1;
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
   localparam int COL_W  = $clog2(MAX_WIDTH + 1);
   localparam int ROW_X  = ROW_W + 5;
   localparam int COL_X  = COL_W + 5;
   localparam int RING_W = $clog2(LINES);
   localparam int ADDR_W = $clog2(LINES * MAX_WIDTH);
   localparam int SUM_W  = $clog2(LINES * LINES * 255 + 1);
   localparam int CNT_W  = $clog2(LINES * LINES + 1);
   localparam int NUM_W  = SUM_W + 2;
   localparam int DEN_W  = CNT_W + 1;
   localparam int STEP_W = $clog2(NUM_W + 1);
   localparam int N_W    = $clog2(RADIUS + 2);
   localparam int CH_W   = bblur_pkg::CH_W;

   bblur_pkg::back_state_type state_ff, state_in;

   logic [ROW_W-1:0]  out_row_ff;
   logic [COL_W-1:0]  out_col_ff;
   logic [RING_W-1:0] out_ring_ff;
   logic [N_W-1:0]    n_ff, limit_ff;
   logic              done_ff;

   logic [ROW_W-1:0]  need_r_ff, rd_row_ff;
   logic [COL_W-1:0]  need_c_ff, c0_ff, rd_col_ff;
   logic [RING_W-1:0] rd_ring_ff;
   logic              rd_valid_ff;

   logic [SUM_W-1:0]  sum_ff [3];
   logic [CNT_W-1:0]  cnt_ff;

   logic [NUM_W-1:0]  num_ff [3];
   logic [NUM_W-1:0]  quo_ff [3];
   logic [DEN_W-1:0]  rem_ff [3];
   logic [DEN_W-1:0]  den_ff;
   logic [STEP_W-1:0] step_ff;

   logic              rsp_valid_ff, last_ff, fdone_ff;
   logic [CH_W-1:0]   mean_ff [3];

   // window of the current center
   logic [ROW_X-1:0]  need_r_x;
   logic [COL_X-1:0]  need_c_x;
   logic [ROW_W-1:0]  need_r, r0;
   logic [COL_W-1:0]  need_c, c0;
   logic [RING_W-1:0] back_rows, r0_ring;
   logic              window_in, go, is_last, rsp_take;
   logic              at_out, at_read, out_home;

   always_comb begin
      need_r_x = ROW_X'(out_row_ff) + ROW_X'(RADIUS);
      need_c_x = COL_X'(out_col_ff) + COL_X'(RADIUS);
      need_r = (need_r_x > ROW_X'(height_eff) - 1'b1) ? height_eff - 1'b1 : ROW_W'(need_r_x);
      need_c = (need_c_x > COL_X'(width_eff) - 1'b1) ? width_eff - 1'b1 : COL_W'(need_c_x);
      r0 = (out_row_ff > ROW_W'(RADIUS)) ? out_row_ff - ROW_W'(RADIUS) : '0;
      c0 = (out_col_ff > COL_W'(RADIUS)) ? out_col_ff - COL_W'(RADIUS) : '0;
      back_rows = RING_W'(out_row_ff - r0);
      r0_ring = (out_ring_ff >= back_rows) ? out_ring_ff - back_rows
                                           : RING_W'(out_ring_ff + RING_W'(LINES) - back_rows);
      window_in = (need_r < in_row) || ((need_r == in_row) && (need_c < in_col));
      go = !done_ff && (n_ff < limit_ff) && (out_row_ff < height_eff)
           && (out_col_ff < width_eff) && window_in;
      is_last = (out_row_ff == height_eff - 1'b1) && (out_col_ff == width_eff - 1'b1);
   end

   assign rsp_take = rsp_valid_ff && !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bblur_pkg::BK_IDLE: begin
            if (!q_stat.empty) begin
               state_in = bblur_pkg::BK_CHECK;
            end
         end
         bblur_pkg::BK_CHECK: begin
            if (n_ff != '0) begin
               state_in = bblur_pkg::BK_OUT;
            end else if (go) begin
               state_in = bblur_pkg::BK_READ;
            end else begin
               state_in = bblur_pkg::BK_IDLE;
            end
         end
         bblur_pkg::BK_READ: begin
            if (rd_row_ff == need_r_ff && rd_col_ff == need_c_ff) begin
               state_in = bblur_pkg::BK_FLUSH;
            end
         end
         bblur_pkg::BK_FLUSH: state_in = bblur_pkg::BK_PREP;
         bblur_pkg::BK_PREP:  state_in = bblur_pkg::BK_DIV;
         bblur_pkg::BK_DIV: begin
            if (step_ff == STEP_W'(1)) begin
               state_in = bblur_pkg::BK_CHECK;
            end
         end
         bblur_pkg::BK_OUT: begin
            if (rsp_take) begin
               state_in = last_ff ? bblur_pkg::BK_IDLE : bblur_pkg::BK_READ;
            end
         end
         default: state_in = bblur_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      pop     = (state_ff == bblur_pkg::BK_IDLE) && !q_stat.empty;
      idle    = (state_ff == bblur_pkg::BK_IDLE);
      rd_addr = ADDR_W'(rd_ring_ff * MAX_WIDTH) + ADDR_W'(rd_col_ff);
   end

   assign frame_restart = (state_ff == bblur_pkg::BK_DIV) && (step_ff == STEP_W'(1)) && is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bblur_pkg::BK_IDLE;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         out_ring_ff  <= '0;
         n_ff         <= '0;
         limit_ff     <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= (state_ff == bblur_pkg::BK_READ);
         if (restart) begin
            out_row_ff  <= '0;
            out_col_ff  <= '0;
            out_ring_ff <= '0;
         end
         unique case (state_ff)
            bblur_pkg::BK_IDLE: begin
               if (!q_stat.empty) begin
                  n_ff     <= '0;
                  done_ff  <= 1'b0;
                  limit_ff <= q_data.drain ? N_W'(1) : N_W'(RADIUS + 1);
               end
            end
            bblur_pkg::BK_CHECK: begin
               // A computed result is held back until we know whether another
               // one follows it in this run.
               if (n_ff != '0) begin
                  rsp_valid_ff <= 1'b1;
                  last_ff      <= !go;
               end
            end
            bblur_pkg::BK_DIV: begin
               if (step_ff == STEP_W'(1)) begin
                  n_ff     <= n_ff + 1'b1;
                  fdone_ff <= is_last;
                  if (is_last) begin
                     out_row_ff  <= '0;
                     out_col_ff  <= '0;
                     out_ring_ff <= '0;
                     done_ff     <= 1'b1;
                  end else if (out_col_ff + 1'b1 >= width_eff) begin
                     out_col_ff  <= '0;
                     out_row_ff  <= out_row_ff + 1'b1;
                     out_ring_ff <= (out_ring_ff == RING_W'(LINES - 1)) ? '0
                                                                         : out_ring_ff + 1'b1;
                  end else begin
                     out_col_ff <= out_col_ff + 1'b1;
                  end
               end
            end
            bblur_pkg::BK_OUT: begin
               if (rsp_take) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Window walk, accumulation and the three restoring dividers, which share one denominator.
   always_ff @(posedge clock) begin
      if (state_ff == bblur_pkg::BK_CHECK && go) begin
         need_r_ff  <= need_r;
         need_c_ff  <= need_c;
         c0_ff      <= c0;
         rd_row_ff  <= r0;
         rd_col_ff  <= c0;
         rd_ring_ff <= r0_ring;
         cnt_ff     <= '0;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         if (state_ff == bblur_pkg::BK_READ) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (rd_col_ff == need_c_ff) begin
               rd_col_ff <= c0_ff;
               if (rd_row_ff != need_r_ff) begin
                  rd_row_ff  <= rd_row_ff + 1'b1;
                  rd_ring_ff <= (rd_ring_ff == RING_W'(LINES - 1)) ? '0 : rd_ring_ff + 1'b1;
               end
            end else begin
               rd_col_ff <= rd_col_ff + 1'b1;
            end
         end
         if (rd_valid_ff) begin
            for (int i = 0; i < 3; i++) begin
               sum_ff[i] <= sum_ff[i] + SUM_W'(rd_data[(2-i)*CH_W +: CH_W]);
            end
         end
      end

      if (state_ff == bblur_pkg::BK_PREP) begin
         den_ff  <= {cnt_ff, 1'b0};
         step_ff <= STEP_W'(NUM_W);
         for (int i = 0; i < 3; i++) begin
            num_ff[i] <= {1'b0, sum_ff[i], 1'b0} + NUM_W'(cnt_ff);
            rem_ff[i] <= '0;
            quo_ff[i] <= '0;
         end
      end else if (state_ff == bblur_pkg::BK_DIV) begin
         step_ff <= step_ff - 1'b1;
         for (int i = 0; i < 3; i++) begin
            logic [DEN_W:0] trial;
            logic           fits;
            trial = {rem_ff[i], num_ff[i][NUM_W-1]};
            fits  = (trial >= {1'b0, den_ff});
            rem_ff[i] <= fits ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
            num_ff[i] <= {num_ff[i][NUM_W-2:0], 1'b0};
            quo_ff[i] <= {quo_ff[i][NUM_W-2:0], fits};
            if (step_ff == STEP_W'(1)) begin
               mean_ff[i] <= {quo_ff[i][CH_W-2:0], fits};
            end
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_blurred_red   = mean_ff[0];
   assign rsp_blurred_green = mean_ff[1];
   assign rsp_blurred_blue  = mean_ff[2];
   assign rsp_last_of_run   = last_ff;
   assign rsp_frame_done    = fdone_ff;

   assign at_out   = (state_ff == bblur_pkg::BK_OUT);
   assign at_read  = (state_ff == bblur_pkg::BK_READ);
   assign out_home = (out_row_ff == '0) && (out_col_ff == '0);

   `BB_IMPLY(a_valid_in_out, clock, reset, rsp_valid_ff, at_out, "result outside output state")
   `BB_IMPLY(a_read_limit, clock, reset, at_read, n_ff < limit_ff, "read past run limit")
   `BB_IMPLY(a_done_last, clock, reset, rsp_valid_ff && rsp_frame_done, rsp_last_of_run, "bad end")
   `BB_NEXT(a_restart_zero, clock, reset, frame_restart && !restart, out_home, "position kept")

endmodule

// ===== rtl/rgb_box_blur_clipped.sv =====
// A result is computed once its window completes, from N window pixels, where N
// is at most (2*RADIUS+1)^2 = 169.
// Throughput: one input transaction at a time. The results of a transaction are paced
// by the single line-store read port, the bit-serial divider and any output stall.
// Reset: position counters clear, the frame width resets to 2048 and the frame height to 1;
// the line store is not cleared and needs no clearing pass.
module rgb_box_blur_clipped #(
   parameter int RADIUS     = 6,
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_blurred_red,
   output logic [7:0]  rsp_blurred_green,
   output logic [7:0]  rsp_blurred_blue,
   output logic        rsp_last_of_run,
   output logic        rsp_frame_done,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [12:0] csr_wdata
);

   localparam int LINES  = 2 * RADIUS + 1;
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
   localparam int COL_W  = $clog2(MAX_WIDTH + 1);
   localparam int ADDR_W = $clog2(LINES * MAX_WIDTH);
   localparam int PIX_W  = 3 * bblur_pkg::CH_W;

   logic [11:0] width_ff;
   logic [12:0] height_ff;
   logic        csr_write;
   logic [COL_W-1:0] width_eff;
   logic [ROW_W-1:0] height_eff;
   logic        restart_cfg, restart_front, frame_restart;

   logic                    push, pop, back_idle, wr_en;
   bblur_pkg::cmd_type      push_data, pop_data;
   bblur_pkg::q_status_type q_stat;
   logic [ADDR_W-1:0]       wr_addr, rd_addr;
   logic [PIX_W-1:0]        wr_data, rd_data;
   logic [ROW_W-1:0]        in_row;
   logic [COL_W-1:0]        in_col;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign restart_cfg   = csr_write;
   assign restart_front = restart_cfg || frame_restart;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 12'd2048;
         height_ff <= 13'd1;
      end else if (csr_write) begin
         unique case (csr_index)
            bblur_pkg::CSR_WIDTH:  width_ff  <= csr_wdata[11:0];
            bblur_pkg::CSR_HEIGHT: height_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      width_eff = (width_ff == '0) ? COL_W'(1)
                : (32'(width_ff) > 32'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH) : COL_W'(width_ff);
      height_eff = (height_ff == '0) ? ROW_W'(1)
                 : (32'(height_ff) > 32'(MAX_HEIGHT)) ? ROW_W'(MAX_HEIGHT) : ROW_W'(height_ff);
   end

   bblur_front #(.RADIUS(RADIUS), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock, .reset, .restart(restart_front), .width_eff, .height_eff,
      .req_valid, .req_stall, .req_operation, .req_red, .req_green, .req_blue,
      .back_idle, .q_stat, .push, .push_data, .wr_en, .wr_addr, .wr_data,
      .in_row, .in_col
   );

   bblur_queue u_queue (
      .clock, .reset, .push, .push_data, .pop, .pop_data, .status(q_stat)
   );

   bblur_ram #(.WIDTH(PIX_W), .DEPTH(LINES * MAX_WIDTH)) u_lines (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   bblur_back #(.RADIUS(RADIUS), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
      .clock, .reset, .restart(restart_cfg), .width_eff, .height_eff, .in_row, .in_col,
      .q_stat, .q_data(pop_data), .pop, .idle(back_idle), .frame_restart,
      .rd_addr, .rd_data, .rsp_valid, .rsp_stall, .rsp_blurred_red, .rsp_blurred_green,
      .rsp_blurred_blue, .rsp_last_of_run, .rsp_frame_done
   );

endmodule

// ===== tb/tb_rgb_box_blur_clipped.sv =====
`timescale 1ns / 1ps

module tb_rgb_box_blur_clipped;

   localparam int RADIUS     = 6;
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 4096;
   localparam int LINES      = 2 * RADIUS + 1;
   localparam int SETTLE     = 600;
   localparam int ITEMS      = 320;
   localparam longint CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic       operation;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_item_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last_of_run;
      logic       frame_done;
   } blurred_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_operation = bblur_pkg::OP_PIXEL;
   logic [7:0]  req_red = '0;
   logic [7:0]  req_green = '0;
   logic [7:0]  req_blue = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_blurred_red;
   logic [7:0]  rsp_blurred_green;
   logic [7:0]  rsp_blurred_blue;
   logic        rsp_last_of_run;
   logic        rsp_frame_done;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = bblur_pkg::CSR_WIDTH;
   logic [12:0] csr_wdata = '0;

   rgb_box_blur_clipped u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_operation(req_operation),
      .req_red(req_red), .req_green(req_green), .req_blue(req_blue),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_blurred_red(rsp_blurred_red), .rsp_blurred_green(rsp_blurred_green),
      .rsp_blurred_blue(rsp_blurred_blue), .rsp_last_of_run(rsp_last_of_run),
      .rsp_frame_done(rsp_frame_done),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   pixel_item_type pixels_to_send[$];
   blurred_type    blurred_expected[$];
   int             mismatches = 0;
   int             items_queued = 0;
   longint         cycle_count = 0;
   logic           hold_sender = 1'b0;
   logic           want_long_hold = 1'b0;

   // Mirror of the filter state.
   logic [23:0] line_mem [LINES * MAX_WIDTH];
   logic [11:0] width_reg = 12'd2048;
   logic [12:0] height_reg = 13'd1;
   int          in_row = 0, in_col = 0, out_row = 0, out_col = 0;

   function automatic int eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
   endfunction

   function automatic int eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
   endfunction

   function automatic logic [7:0] round_mean(int sum, int cnt);
      return 8'((2 * sum + cnt) / (2 * cnt));
   endfunction

   function automatic void emit_centers(int limit);
      int w, h, n, need_r, need_c, r0, c0, sr, sg, sb, cnt, idx;
      blurred_type b;
      w = eff_width();
      h = eff_height();
      n = 0;
      while (n < limit && out_row < h && out_col < w) begin
         need_r = (out_row + RADIUS > h - 1) ? h - 1 : out_row + RADIUS;
         need_c = (out_col + RADIUS > w - 1) ? w - 1 : out_col + RADIUS;
         if (!(need_r < in_row || (need_r == in_row && need_c < in_col))) break;
         r0 = (out_row > RADIUS) ? out_row - RADIUS : 0;
         c0 = (out_col > RADIUS) ? out_col - RADIUS : 0;
         sr = 0; sg = 0; sb = 0; cnt = 0;
         for (int r = r0; r <= need_r; r++) begin
            for (int c = c0; c <= need_c; c++) begin
               idx = (r % LINES) * MAX_WIDTH + c;
               sr += line_mem[idx][23:16];
               sg += line_mem[idx][15:8];
               sb += line_mem[idx][7:0];
               cnt++;
            end
         end
         b.red = round_mean(sr, cnt);
         b.green = round_mean(sg, cnt);
         b.blue = round_mean(sb, cnt);
         b.last_of_run = 1'b0;
         b.frame_done = (out_row == h - 1 && out_col == w - 1);
         blurred_expected.push_back(b);
         n++;
         if (b.frame_done) begin
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
            break;
         end
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
      if (n > 0) begin
         b = blurred_expected.pop_back();
         b.last_of_run = 1'b1;
         blurred_expected.push_back(b);
      end
   endfunction

   function automatic void predict_blur(pixel_item_type it);
      if (it.operation == bblur_pkg::OP_DRAIN) begin
         emit_centers(1);
      end else if (in_row < eff_height() && in_col < eff_width()) begin
         line_mem[(in_row % LINES) * MAX_WIDTH + in_col] = {it.red, it.green, it.blue};
         in_col++;
         if (in_col >= eff_width()) begin
            in_col = 0;
            in_row++;
         end
         emit_centers(RADIUS + 1);
      end
   endfunction

   // Sender: bursts of random length separated by random gaps.
   pixel_item_type cur_item;
   int burst_left = 0, gap_left = 0;

   always @(posedge clock) begin
      logic next_valid;
      next_valid = req_valid;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_blur(cur_item);
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pixels_to_send.size() > 0 && !hold_sender) begin
               cur_item = pixels_to_send.pop_front();
               req_operation <= cur_item.operation;
               req_red <= cur_item.red;
               req_green <= cur_item.green;
               req_blue <= cur_item.blue;
               next_valid = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 30);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
      end
      req_valid <= next_valid;
   end

   // Receiver: stall pattern changes mode at random, with one long hold-off on request.
   int stall_mode = 0, mode_left = 0, hold_left = 0;
   logic hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (want_long_hold && !hold_done) begin
         if (hold_left == 0) hold_left = 3000;
         hold_left--;
         if (hold_left == 0) hold_done = 1'b1;
         rsp_stall <= (hold_left != 0);
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 400);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= 1'($urandom_range(0, 1));
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Result checker.
   always @(posedge clock) begin
      blurred_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_blurred_red, rsp_blurred_green, rsp_blurred_blue,
                rsp_last_of_run, rsp_frame_done};
         if (blurred_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transaction: %h", got);
         end else begin
            want = blurred_expected.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp r=%0d g=%0d b=%0d last=%0b done=%0b, %s",
                           want.red, want.green, want.blue, want.last_of_run,
                           want.frame_done,
                           $sformatf("act r=%0d g=%0d b=%0d last=%0b done=%0b",
                                     got.red, got.green, got.blue, got.last_of_run,
                                     got.frame_done));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic settle();
      while (pixels_to_send.size() > 0 || req_valid || blurred_expected.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [12:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == bblur_pkg::CSR_WIDTH) width_reg = value[11:0];
      else height_reg = value;
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
   endtask

   task automatic add_item(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      pixel_item_type it;
      it.operation = op;
      it.red = r;
      it.green = g;
      it.blue = b;
      pixels_to_send.push_back(it);
      items_queued++;
   endtask

   task automatic add_random_pixels(int count);
      repeat (count) add_item(bblur_pkg::OP_PIXEL, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
   endtask

   // Enough drain transactions to flush whatever the last pixel left pending.
   task automatic add_drains(int w, int h);
      int n;
      n = (w * h < w * (RADIUS + 1) + RADIUS + 1) ? w * h : w * (RADIUS + 1) + RADIUS + 1;
      repeat (n + 1) add_item(bblur_pkg::OP_DRAIN, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
   endtask

   initial begin
      int w, h, n, left, frames;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry: one row of 2048, abandoned part way by a register write.
      add_item(bblur_pkg::OP_DRAIN, 8'h00, 8'h00, 8'h00);
      add_random_pixels(20);
      settle();

      // Zero registers act as a 1x1 frame.
      write_reg(bblur_pkg::CSR_WIDTH, 13'd0);
      write_reg(bblur_pkg::CSR_HEIGHT, 13'd0);
      add_item(bblur_pkg::OP_PIXEL, 8'hff, 8'hff, 8'hff);
      add_item(bblur_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00);
      add_item(bblur_pkg::OP_DRAIN, 8'hff, 8'hff, 8'hff);
      settle();

      // Tall narrow frame wraps the line store; a pixel after the frame is ignored.
      write_reg(bblur_pkg::CSR_WIDTH, 13'd3);
      write_reg(bblur_pkg::CSR_HEIGHT, 13'd20);
      for (int i = 0; i < 60; i++)
         add_item(bblur_pkg::OP_PIXEL, (i % 2) ? 8'hff : 8'h00, (i % 3) ? 8'hff : 8'h00,
                  (i % 5) ? 8'h00 : 8'hff);
      add_item(bblur_pkg::OP_PIXEL, 8'h12, 8'h34, 8'h56);
      add_drains(3, 20);
      settle();

      // Oversized registers clamp to the maximum width and height.
      write_reg(bblur_pkg::CSR_WIDTH, 13'd4095);
      write_reg(bblur_pkg::CSR_HEIGHT, 13'd1);
      add_random_pixels(40);
      settle();
      write_reg(bblur_pkg::CSR_WIDTH, 13'd1);
      write_reg(bblur_pkg::CSR_HEIGHT, 13'd8191);
      add_random_pixels(30);
      settle();

      // Random frames, small sizes, some abandoned part way.
      frames = 0;
      while (items_queued < ITEMS) begin
         w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
         h = $urandom_range(1, 16);
         write_reg(bblur_pkg::CSR_WIDTH, 13'(w));
         write_reg(bblur_pkg::CSR_HEIGHT, 13'(h));
         n = w * h;
         if (frames > 0 && !want_long_hold) want_long_hold = 1'b1;
         else if ($urandom_range(0, 5) == 0) n = $urandom_range(1, w * h);
         left = ITEMS - items_queued;
         if (2 * n + 1 > left) n = (left > 2) ? left / 2 : 1;
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
               add_item(bblur_pkg::OP_DRAIN, 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            add_random_pixels(1);
         end
         if (n == w * h) add_drains(w, h);
         // The sender waits for every result before the next frame.
         while (pixels_to_send.size() > 0 || req_valid) @(posedge clock);
         hold_sender = 1'b1;
         while (blurred_expected.size() > 0) @(posedge clock);
         hold_sender = 1'b0;
         settle();
         frames++;
      end

      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bblur_pkg.sv
rtl/bblur_ram.sv
rtl/bblur_queue.sv
rtl/bblur_front.sv
rtl/bblur_back.sv
rtl/rgb_box_blur_clipped.sv
tb/tb_rgb_box_blur_clipped.sv
